// File: hw/rtl/bptm_pkg.sv
// bptm_pkg: shared widths, gauge breakpoint tables and control structs
// for the battery percent trimmed-mean block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bptm_pkg;

  localparam int DEF_WINDOW      = 10;
  localparam int DEF_SAMPLE_BITS = 12;
  localparam int ADC_W           = 12;
  localparam int PCT_W           = 7;
  localparam int PT_W            = 12;
  localparam int SEG_W           = 4;
  localparam int OFF_W           = 9;
  localparam int OFF10_W         = 13;
  localparam int POINT_COUNT     = 11;
  localparam int SEG_COUNT       = POINT_COUNT - 1;
  localparam int STEP_COUNT      = 9;

  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
  localparam logic [PCT_W-1:0] PCT_STEP  = 7'd10;

  typedef struct packed {
    logic rd_vld;
    logic rd_last;
  } ring_stat_t;

  typedef struct packed {
    logic mul_en;
    logic seg_en;
  } gauge_ctl_t;

  // breakpoint voltage for each table index
  function automatic logic [PT_W-1:0] gauge_point(input logic [SEG_W-1:0] idx);
    logic [PT_W-1:0] pt;
    case (idx)
      4'd0:    pt = 12'd2000;
      4'd1:    pt = 12'd2265;
      4'd2:    pt = 12'd2300;
      4'd3:    pt = 12'd2320;
      4'd4:    pt = 12'd2330;
      4'd5:    pt = 12'd2350;
      4'd6:    pt = 12'd2383;
      4'd7:    pt = 12'd2415;
      4'd8:    pt = 12'd2455;
      4'd9:    pt = 12'd2505;
      4'd10:   pt = 12'd2591;
      default: pt = 12'd2591;
    endcase
    return pt;
  endfunction

  // segment span times step k: offset*10 at or above this gives a quotient of at least k
  function automatic logic [PT_W-1:0] gauge_thresh(input logic [SEG_W-1:0] seg,
                                                   input logic [SEG_W-1:0] k);
    logic [PT_W-1:0] span;
    logic [PT_W-1:0] prod;
    span = gauge_point(seg + 4'd1) - gauge_point(seg);
    prod = PT_W'(span * PT_W'(k));
    return prod;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bptm_ring.sv
// bptm_ring: sample ring memory with per-entry valid bits and a read sweep
// depends on bptm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bptm_ring #(
  parameter int WINDOW      = bptm_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = bptm_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [SAMPLE_BITS-1:0] wr_data,
  output logic      [SAMPLE_BITS-1:0] rd_data,
  output bptm_pkg::ring_stat_t        stat
);
  import bptm_pkg::*;

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

  logic [SAMPLE_BITS-1:0] mem_r [WINDOW];
  logic [WINDOW-1:0]      valid_r;
  logic [AW-1:0]          slot_r;
  logic [AW-1:0]          addr_r;
  logic                   busy_r;
  logic                   dv_r;
  logic                   last_r;
  logic [SAMPLE_BITS-1:0] q_r;
  logic                   qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      valid_r <= '0;
      addr_r  <= '0;
      busy_r  <= 1'b0;
      dv_r    <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      dv_r   <= busy_r;
      last_r <= busy_r && (addr_r == LAST);
      if (wr_en) begin
        valid_r[slot_r] <= 1'b1;
        slot_r          <= (slot_r == LAST) ? '0 : slot_r + 1'b1;
        busy_r          <= 1'b1;
        addr_r          <= '0;
      end else if (busy_r) begin
        addr_r <= addr_r + 1'b1;
        if (addr_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // single write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[slot_r] <= wr_data;
    end
    if (busy_r) begin
      q_r  <= mem_r[addr_r];
      qv_r <= valid_r[addr_r];
    end
  end

  // never-written entries read as the reset value of zero
  assign rd_data      = qv_r ? q_r : '0;
  assign stat.rd_vld  = dv_r;
  assign stat.rd_last = last_r;

endmodule

`default_nettype wire

// File: hw/rtl/bptm_accum.sv
// bptm_accum: running sum, minimum and maximum over the ring sweep,
// then the trimmed sum; depends on bptm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bptm_accum #(
  parameter int WINDOW      = bptm_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = bptm_pkg::DEF_SAMPLE_BITS,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  wire logic                   clk,
  input  wire logic                   clr,
  input  wire logic                   trim_en,
  input  wire bptm_pkg::ring_stat_t   stat,
  input  wire logic [SAMPLE_BITS-1:0] data,
  output logic      [SUM_W-1:0]       trim
);
  import bptm_pkg::*;

  logic [SUM_W-1:0]       sum_r;
  logic [SAMPLE_BITS-1:0] lo_r;
  logic [SAMPLE_BITS-1:0] hi_r;
  logic [SUM_W-1:0]       trim_r;

  always_ff @(posedge clk) begin
    if (clr) begin
      sum_r <= '0;
      lo_r  <= '1;
      hi_r  <= '0;
    end else if (stat.rd_vld) begin
      sum_r <= sum_r + SUM_W'(data);
      if (data < lo_r) begin
        lo_r <= data;
      end
      if (data > hi_r) begin
        hi_r <= data;
      end
    end
    if (trim_en) begin
      trim_r <= sum_r - SUM_W'(lo_r) - SUM_W'(hi_r);
    end
  end

  assign trim = trim_r;

endmodule

`default_nettype wire

// File: hw/rtl/bptm_gauge.sv
// bptm_gauge: divide the trimmed sum by window-2 via reciprocal multiply,
// then map the mean through the piecewise-linear table; depends on bptm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bptm_gauge #(
  parameter int WINDOW      = bptm_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = bptm_pkg::DEF_SAMPLE_BITS,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  wire logic                        clk,
  input  wire bptm_pkg::gauge_ctl_t        ctl,
  input  wire logic [SUM_W-1:0]            trim,
  output logic      [bptm_pkg::PCT_W-1:0]  pct
);
  import bptm_pkg::*;

  localparam int DIV    = WINDOW - 2;
  localparam int SHIFT  = SUM_W + $clog2(DIV);
  localparam int M_W    = SUM_W + 1;
  localparam int PROD_W = SUM_W + M_W;
  // ceil(2^SHIFT / DIV): exact floor quotient for every SUM_W-bit dividend
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));

  logic [PROD_W-1:0]      prod_r;
  logic [SAMPLE_BITS-1:0] mean;
  logic                   full_c;
  logic                   zero_c;
  logic [SEG_W-1:0]       seg_c;
  logic [SAMPLE_BITS-1:0] diff_c;
  logic                   full_r;
  logic                   zero_r;
  logic [SEG_W-1:0]       seg_r;
  logic [OFF_W-1:0]       off_r;
  logic [OFF10_W-1:0]     off10;
  logic [SEG_W-1:0]       q_c;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(trim) * PROD_W'(RECIP);
    end
  end

  assign mean = prod_r[SHIFT +: SAMPLE_BITS];

  // segment pick: count of inner breakpoints at or below the mean
  always_comb begin
    full_c = mean >= SAMPLE_BITS'(gauge_point(SEG_W'(SEG_COUNT)));
    zero_c = mean <= SAMPLE_BITS'(gauge_point('0));
    seg_c  = '0;
    for (int i = 1; i < SEG_COUNT; i++) begin
      if (mean >= SAMPLE_BITS'(gauge_point(SEG_W'(i)))) begin
        seg_c = seg_c + 1'b1;
      end
    end
    diff_c = mean - SAMPLE_BITS'(gauge_point(seg_c));
  end

  always_ff @(posedge clk) begin
    if (ctl.seg_en) begin
      full_r <= full_c;
      zero_r <= zero_c;
      seg_r  <= seg_c;
      off_r  <= diff_c[OFF_W-1:0];
    end
  end

  // offset*10 / span as a count of span multiples reached
  assign off10 = OFF10_W'({off_r, 3'b000}) + OFF10_W'({off_r, 1'b0});

  always_comb begin
    q_c = '0;
    for (int k = 1; k <= STEP_COUNT; k++) begin
      if (off10 >= OFF10_W'(gauge_thresh(seg_r, SEG_W'(k)))) begin
        q_c = q_c + 1'b1;
      end
    end
    if (full_r) begin
      pct = PCT_FULL;
    end else if (zero_r) begin
      pct = PCT_EMPTY;
    end else begin
      pct = PCT_W'(PCT_W'(seg_r) * PCT_STEP) + PCT_W'(q_c);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/battery_percent_trimmed_mean.sv
// battery_percent_trimmed_mean: top level, sequencer and result register
// depends on bptm_pkg, bptm_ring, bptm_accum, bptm_gauge
//
//   channel  ports                              word
//   in       in_valid in_ready in_adc_sample    one 12-bit adc sample
//   out      out_valid out_ready                one charge percent, 0..100
//            out_charge_percent
//
// each word runs from accept through the one-entry-per-cycle read sweep of the
// ring memory followed by trim, multiply, segment and output steps before the
// next accept can be taken. reset is synchronous and clears all ring valid
// bits at once, so no clearing pass is needed. a stalled output holds the
// sequencer in its last step; in_ready is high only while idle.
`timescale 1ns / 1ps
`default_nettype none

module battery_percent_trimmed_mean #(
  parameter int WINDOW      = bptm_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = bptm_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bptm_pkg::ADC_W-1:0]  in_adc_sample,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [bptm_pkg::PCT_W-1:0]  out_charge_percent
);
  import bptm_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_TRIM = 6'b000100,
    S_MUL  = 6'b001000,
    S_SEG  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                 state_r;
  state_t                 state_nxt;
  logic                   accept;
  logic                   load;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic [SAMPLE_BITS-1:0] rd_data;
  ring_stat_t             stat;
  logic [SUM_W-1:0]       trim;
  gauge_ctl_t             gctl;
  logic [PCT_W-1:0]       pct;
  logic                   out_valid_r;
  logic [PCT_W-1:0]       out_pct_r;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign wr_data  = SAMPLE_BITS'(in_adc_sample);

  assign gctl.mul_en = (state_r == S_MUL);
  assign gctl.seg_en = (state_r == S_SEG);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.rd_vld && stat.rd_last) begin
          state_nxt = S_TRIM;
        end
      end
      S_TRIM: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SEG;
      S_SEG:  state_nxt = S_DONE;
      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pct_r <= pct;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_charge_percent = out_pct_r;

  bptm_ring #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .stat    (stat)
  );

  bptm_accum #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_accum (
    .clk     (clk),
    .clr     (accept),
    .trim_en (state_r == S_TRIM),
    .stat    (stat),
    .data    (rd_data),
    .trim    (trim)
  );

  bptm_gauge #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_gauge (
    .clk  (clk),
    .ctl  (gctl),
    .trim (trim),
    .pct  (pct)
  );

endmodule

`default_nettype wire
